// ===== rtl/zipt_pkg.sv =====
// Package: widths, codes, control word and microprogram of the zoned PID throttle.
package zipt_pkg;

  localparam int SUM_W     = 32;
  localparam int IN_W      = 16;
  localparam int ERR_W     = IN_W + 1;
  localparam int MAG_IN_W  = IN_W;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int GAIN_W    = 24;
  localparam int CHUNK_W   = 24;
  localparam int MAG_W     = 2 * CHUNK_W;
  localparam int MUL_W     = CHUNK_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int I_SAT_SH  = 50;
  localparam int IP_W      = I_SAT_SH + 1;
  localparam int HI_OK_W   = I_SAT_SH - CHUNK_W;
  localparam int ACC_W     = IP_W + 2;
  localparam int FRAC_W    = 16;
  localparam int FLR_W     = ACC_W - FRAC_W;
  localparam int T_W       = FLR_W + 1;
  localparam int THR_W     = 16;
  localparam int PWM_W     = 16;
  localparam int SCL_W     = 10;
  localparam int SPROD_W   = THR_W + SCL_W;
  localparam int SROUND_W  = SPROD_W + 1;
  localparam int SCALED_W  = SROUND_W - FRAC_W;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [MAG_IN_W-1:0] COARSE_LSB = MAG_IN_W'(77);
  localparam logic [MAG_IN_W-1:0] FINE_LSB   = MAG_IN_W'(26);
  localparam logic [IP_W-1:0]     I_SAT      = IP_W'(1) << I_SAT_SH;
  localparam logic [SCL_W-1:0]    PWM_SCALE  = SCL_W'(1000);
  localparam logic [SROUND_W-1:0] PWM_ROUND  = SROUND_W'(65535);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [15:0] RST_TARGET   = 16'd1024;
  localparam logic [23:0] RST_GAIN_P   = 24'd83886;
  localparam logic [23:0] RST_GAIN_I   = 24'd0;
  localparam logic [23:0] RST_GAIN_D   = 24'd0;
  localparam logic [23:0] RST_GAIN_F   = 24'd8389;
  localparam logic [15:0] RST_THR_MIN  = 16'd5898;
  localparam logic [15:0] RST_THR_MAX  = 16'd52429;
  localparam logic [15:0] RST_PWM_BASE = 16'd18900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
    REG_GAIN_F, REG_THR_MIN, REG_THR_MAX, REG_PWM_BASE
  } reg_idx_t;

  typedef enum logic [1:0] {ZONE_HOLD, ZONE_FINE, ZONE_COARSE} zone_t;

  typedef enum logic [1:0] {A_ERR, A_DIFF, A_SUM_LO, A_SUM_HI} a_sel_t;
  typedef enum logic [1:0] {B_ZONE, B_GD, B_GI} b_sel_t;
  typedef enum logic [2:0] {
    OP_NONE, OP_ACC_LOAD, OP_ACC_ADD, OP_IP_LOAD, OP_IP_SAT, OP_ACC_ADD_IP, OP_THR, OP_OUT
  } op_t;
  typedef enum logic [1:0] {J_NEXT, J_ZONE, J_GOTO, J_END} jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    op_t               op;
    jmp_t              jmp;
    logic              sum_upd;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic  start;
    zone_t zone;
    logic  out_full;
  } seq_stat_t;

  localparam logic [STEP_W-1:0] ST_FINE = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_FIN  = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_OUT  = STEP_W'(8);

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    c = '{a_sel: A_ERR, b_sel: B_ZONE, op: OP_NONE, jmp: J_NEXT, sum_upd: 1'b0, tgt: '0};
    case (s)
      4'd0: begin
        c.jmp = J_ZONE;
      end
      4'd1: begin
        c.a_sel = A_DIFF;
        c.b_sel = B_GD;
        c.op    = OP_ACC_LOAD;
      end
      4'd2: begin
        c.a_sel = A_SUM_LO;
        c.b_sel = B_GI;
        c.op    = OP_ACC_ADD;
      end
      4'd3: begin
        c.a_sel = A_SUM_HI;
        c.b_sel = B_GI;
        c.op    = OP_IP_LOAD;
      end
      4'd4: begin
        c.op = OP_IP_SAT;
      end
      4'd5: begin
        c.op  = OP_ACC_ADD_IP;
        c.jmp = J_GOTO;
        c.tgt = ST_FIN;
      end
      4'd6: begin
        c.op      = OP_ACC_LOAD;
        c.sum_upd = 1'b1;
      end
      4'd7: begin
        c.op = OP_THR;
      end
      4'd8: begin
        c.op  = OP_OUT;
        c.jmp = J_END;
      end
      default: begin
        c.jmp = J_GOTO;
        c.tgt = ST_OUT;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/zipt_seq.sv =====
// Microprogram sequencer: step counter, control ROM and jump logic.
module zipt_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  zipt_pkg::seq_stat_t stat,
  output zipt_pkg::ctrl_t     ctrl,
  output logic                busy
);

  logic                        busy_r, busy_nxt;
  logic [zipt_pkg::STEP_W-1:0] step_r, step_nxt;

  assign ctrl = zipt_pkg::ucode(step_r);
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (stat.start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else begin
      case (ctrl.jmp)
        zipt_pkg::J_NEXT: step_nxt = step_r + 1'b1;
        zipt_pkg::J_GOTO: step_nxt = ctrl.tgt;
        zipt_pkg::J_ZONE: begin
          case (stat.zone)
            zipt_pkg::ZONE_HOLD: step_nxt = zipt_pkg::ST_FIN;
            zipt_pkg::ZONE_FINE: step_nxt = zipt_pkg::ST_FINE;
            default:             step_nxt = step_r + 1'b1;
          endcase
        end
        zipt_pkg::J_END: begin
          if (!stat.out_full) busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/zoned_incremental_pid_throttle_top.sv =====
// Top level: zoned incremental PID throttle with shared multiplier datapath.
// Coarse-zone samples run the whole microprogram; fine-zone samples jump to the fine step and
// hold-zone samples to the throttle step. A sample is taken only while the microprogram is idle,
// and its steps share the single 25x25 multiplier.
// A new sample is taken while a finished result waits in the output register.
// Reset (rst_n low, synchronous) loads register defaults and zeroes throttle, error and sum.
module zoned_incremental_pid_throttle_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] measured_freq
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] pwm_compare, [31:16] throttle_level, [33:32] zone
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int SW = zipt_pkg::SUM_W;

  logic [15:0] target_r, throttle_min_r, throttle_max_r, pwm_base_r;
  logic [23:0] gain_p_r, gain_i_r, gain_d_r, gain_fine_r;

  logic [zipt_pkg::THR_W-1:0]          thr_state_r;
  logic signed [zipt_pkg::ERR_W-1:0]   prev_err_r, err_r;
  logic signed [SW-1:0]                err_sum_r;
  zipt_pkg::zone_t                     zone_r;
  logic signed [zipt_pkg::PROD_W-1:0]  prod_r;
  logic signed [zipt_pkg::ACC_W-1:0]   acc_r;
  logic [zipt_pkg::IP_W-1:0]           ip_r;
  logic                                out_valid_r;
  logic [zipt_pkg::PWM_W-1:0]          out_pwm_r;
  logic [zipt_pkg::THR_W-1:0]          out_thr_r;
  zipt_pkg::zone_t                     out_zone_r;

  zipt_pkg::ctrl_t     ctrl;
  zipt_pkg::seq_stat_t stat;
  logic                busy;
  logic                in_xfer, out_full, en, out_fire;

  logic signed [zipt_pkg::ERR_W-1:0]    err_in;
  logic [zipt_pkg::MAG_IN_W-1:0]        mag_in;
  zipt_pkg::zone_t                      zone_in;
  logic signed [zipt_pkg::DIFF_W-1:0]   diff;
  logic                                 sum_neg;
  logic [SW-1:0]                        sum_mag;
  logic [zipt_pkg::MAG_W-1:0]           mag_ext;
  logic signed [zipt_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [zipt_pkg::GAIN_W-1:0]          gain_sel;
  logic signed [zipt_pkg::PROD_W-1:0]   prod_nxt;
  logic [zipt_pkg::IP_W-1:0]            ip_sum, ip_nxt;
  logic signed [zipt_pkg::ACC_W-1:0]    ip_s;
  logic signed [zipt_pkg::FLR_W-1:0]    flr;
  logic signed [zipt_pkg::T_W-1:0]      t_raw, t_max, t_min, t_clamp;
  logic signed [SW:0]                   sum_add;
  logic signed [SW-1:0]                 sum_nxt;
  logic [zipt_pkg::SPROD_W-1:0]         sprod;
  logic [zipt_pkg::SROUND_W-1:0]        sround;
  logic [zipt_pkg::PWM_W-1:0]           scaled, pwm_nxt;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !busy;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_full   = out_valid_r && !out_tready;
  assign en         = busy;
  assign out_fire   = en && (ctrl.op == zipt_pkg::OP_OUT) && !out_full;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_zone_r, out_thr_r, out_pwm_r};

  assign stat = '{start: in_xfer, zone: zone_r, out_full: out_full};

  zipt_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  always_comb begin
    err_in = $signed({1'b0, target_r}) - $signed({1'b0, in_tdata});
    mag_in = err_in[zipt_pkg::ERR_W-1] ? zipt_pkg::MAG_IN_W'(-err_in)
                                       : err_in[zipt_pkg::MAG_IN_W-1:0];
    if (mag_in >= zipt_pkg::COARSE_LSB) zone_in = zipt_pkg::ZONE_COARSE;
    else if (mag_in >= zipt_pkg::FINE_LSB) zone_in = zipt_pkg::ZONE_FINE;
    else zone_in = zipt_pkg::ZONE_HOLD;
  end

  always_comb begin
    diff    = zipt_pkg::DIFF_W'(err_r) - zipt_pkg::DIFF_W'(prev_err_r);
    sum_neg = err_sum_r[SW-1];
    sum_mag = sum_neg ? SW'(~err_sum_r + 1'b1) : SW'(err_sum_r);
    mag_ext = zipt_pkg::MAG_W'(sum_mag);
    case (ctrl.a_sel)
      zipt_pkg::A_ERR:    mul_a = zipt_pkg::MUL_W'(err_r);
      zipt_pkg::A_DIFF:   mul_a = zipt_pkg::MUL_W'(diff);
      zipt_pkg::A_SUM_LO: mul_a = $signed({1'b0, mag_ext[zipt_pkg::CHUNK_W-1:0]});
      zipt_pkg::A_SUM_HI: mul_a = $signed({1'b0, mag_ext[zipt_pkg::MAG_W-1:zipt_pkg::CHUNK_W]});
      default:            mul_a = '0;
    endcase
    case (ctrl.b_sel)
      zipt_pkg::B_ZONE: gain_sel = (zone_r == zipt_pkg::ZONE_FINE) ? gain_fine_r : gain_p_r;
      zipt_pkg::B_GD:   gain_sel = gain_d_r;
      zipt_pkg::B_GI:   gain_sel = gain_i_r;
      default:          gain_sel = '0;
    endcase
    mul_b    = $signed({1'b0, gain_sel});
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    ip_sum = ip_r + (zipt_pkg::IP_W'(prod_r[zipt_pkg::HI_OK_W-1:0]) << zipt_pkg::CHUNK_W);
    if (|prod_r[zipt_pkg::PROD_W-1:zipt_pkg::HI_OK_W]) ip_nxt = zipt_pkg::I_SAT;
    else if (ip_sum > zipt_pkg::I_SAT) ip_nxt = zipt_pkg::I_SAT;
    else ip_nxt = ip_sum;
    ip_s = $signed(zipt_pkg::ACC_W'(ip_r));
  end

  always_comb begin
    flr     = $signed(acc_r[zipt_pkg::ACC_W-1:zipt_pkg::FRAC_W]);
    t_raw   = zipt_pkg::T_W'($signed({1'b0, thr_state_r})) + zipt_pkg::T_W'(flr);
    t_max   = zipt_pkg::T_W'($signed({1'b0, throttle_max_r}));
    t_min   = zipt_pkg::T_W'($signed({1'b0, throttle_min_r}));
    if (t_raw > t_max) t_clamp = t_max;
    else if (t_raw < t_min) t_clamp = t_min;
    else t_clamp = t_raw;
  end

  always_comb begin
    sum_add = (SW+1)'(err_sum_r) + (SW+1)'(err_r);
    if (sum_add[SW] != sum_add[SW-1]) sum_nxt = sum_add[SW] ? zipt_pkg::SUM_MIN : zipt_pkg::SUM_MAX;
    else sum_nxt = sum_add[SW-1:0];
  end

  always_comb begin
    sprod   = zipt_pkg::SPROD_W'(thr_state_r) * zipt_pkg::SPROD_W'(zipt_pkg::PWM_SCALE);
    sround  = zipt_pkg::SROUND_W'(sprod) + zipt_pkg::PWM_ROUND;
    scaled  = zipt_pkg::PWM_W'(sround[zipt_pkg::SROUND_W-1:zipt_pkg::FRAC_W]);
    pwm_nxt = (scaled > pwm_base_r) ? '0 : pwm_base_r - scaled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r       <= zipt_pkg::RST_TARGET;
      gain_p_r       <= zipt_pkg::RST_GAIN_P;
      gain_i_r       <= zipt_pkg::RST_GAIN_I;
      gain_d_r       <= zipt_pkg::RST_GAIN_D;
      gain_fine_r    <= zipt_pkg::RST_GAIN_F;
      throttle_min_r <= zipt_pkg::RST_THR_MIN;
      throttle_max_r <= zipt_pkg::RST_THR_MAX;
      pwm_base_r     <= zipt_pkg::RST_PWM_BASE;
    end else if (cfg_valid && cfg_ready) begin
      case (zipt_pkg::reg_idx_t'(cfg_index))
        zipt_pkg::REG_TARGET:   target_r       <= cfg_data[15:0];
        zipt_pkg::REG_GAIN_P:   gain_p_r       <= cfg_data;
        zipt_pkg::REG_GAIN_I:   gain_i_r       <= cfg_data;
        zipt_pkg::REG_GAIN_D:   gain_d_r       <= cfg_data;
        zipt_pkg::REG_GAIN_F:   gain_fine_r    <= cfg_data;
        zipt_pkg::REG_THR_MIN:  throttle_min_r <= cfg_data[15:0];
        zipt_pkg::REG_THR_MAX:  throttle_max_r <= cfg_data[15:0];
        zipt_pkg::REG_PWM_BASE: pwm_base_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_state_r <= '0;
      prev_err_r  <= '0;
      err_sum_r   <= '0;
      ip_r        <= '0;
      zone_r      <= zipt_pkg::ZONE_HOLD;
    end else begin
      if (in_xfer) zone_r <= zone_in;
      if (en && ctrl.sum_upd && zone_r == zipt_pkg::ZONE_FINE) err_sum_r <= sum_nxt;
      if (en && ctrl.op == zipt_pkg::OP_IP_LOAD) ip_r <= zipt_pkg::IP_W'($unsigned(prod_r));
      if (en && ctrl.op == zipt_pkg::OP_IP_SAT) ip_r <= ip_nxt;
      if (en && ctrl.op == zipt_pkg::OP_THR) begin
        thr_state_r <= t_clamp[zipt_pkg::THR_W-1:0];
        prev_err_r  <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_xfer) begin
      err_r <= err_in;
      acc_r <= '0;
    end else if (en) begin
      case (ctrl.op)
        zipt_pkg::OP_ACC_LOAD:   acc_r <= zipt_pkg::ACC_W'(prod_r);
        zipt_pkg::OP_ACC_ADD:    acc_r <= acc_r + zipt_pkg::ACC_W'(prod_r);
        zipt_pkg::OP_ACC_ADD_IP: acc_r <= sum_neg ? acc_r - ip_s : acc_r + ip_s;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
      out_pwm_r   <= pwm_nxt;
      out_thr_r   <= thr_state_r;
      out_zone_r  <= zone_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_out_from_ucode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy && ctrl.op == zipt_pkg::OP_OUT))
    else $error("result raised outside the output step");

  a_sum_fine_only: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && err_sum_r != $past(err_sum_r))
      |-> $past(busy && ctrl.sum_upd && zone_r == zipt_pkg::ZONE_FINE))
    else $error("error sum changed outside the fine zone");

  a_ip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ip_r <= zipt_pkg::I_SAT)
    else $error("integral product above saturation limit");

  a_thr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(busy && ctrl.op == zipt_pkg::OP_THR) && throttle_min_r <= throttle_max_r)
      |-> (thr_state_r >= throttle_min_r && thr_state_r <= throttle_max_r))
    else $error("throttle outside clamp limits");

endmodule
